@@ sv/palette_store_with_reverse_lookup_assert.svh @@
// Assertion macros used by the palette store controller.
`ifndef PALETTE_STORE_WITH_REVERSE_LOOKUP_ASSERT_SVH
`define PALETTE_STORE_WITH_REVERSE_LOOKUP_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define PLT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("palette store: implication check failed");

// Next-cycle implication, disabled while in reset.
`define PLT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("palette store: next-cycle check failed");

`endif

@@ sv/plt_pkg.sv @@
// Shared types, constants and helpers for the palette store.
package plt_pkg;

  localparam int PLT_ENTRIES = 256;
  localparam int IDX_FIELD_W = 8;
  localparam int CH_RAW_W    = 8;
  localparam int CH_SAVE_W   = 6;
  localparam int PIX_W       = 3 * CH_RAW_W;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_READ    = 2'd1,
    OP_RESOLVE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

  // Widen a 6-bit VGA level to 8 bits by replicating its top bits.
  function automatic logic [CH_RAW_W-1:0] widen6(input logic [CH_RAW_W-1:0] raw);
    logic [CH_SAVE_W-1:0] v;
    v = raw[CH_SAVE_W-1:0];
    return {v, v[CH_SAVE_W-1 -: 2]};
  endfunction

endpackage

@@ sv/palette_store_with_reverse_lookup.sv @@
// Throughput: one item at a time; in_ready returns once the result is in the output register.
// A resolve walks the palette memory read port one entry per cycle through one comparator.
// Reset (rst_n low, synchronous): all palette entries read as zero, no result pending.
// Entry valid bits replace a clearing pass, so items are taken from the first cycle.
module palette_store_with_reverse_lookup
  import plt_pkg::*;
#(
  parameter int ENTRIES = PLT_ENTRIES
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             in_operation,
  input  logic [IDX_FIELD_W-1:0] in_entry_index,
  input  logic [CH_RAW_W-1:0]    in_red,
  input  logic [CH_RAW_W-1:0]    in_green,
  input  logic [CH_RAW_W-1:0]    in_blue,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [IDX_FIELD_W-1:0] out_found_index,
  output logic                   out_found,
  output logic [CH_SAVE_W-1:0]   out_red_out,
  output logic [CH_SAVE_W-1:0]   out_green_out,
  output logic [CH_SAVE_W-1:0]   out_blue_out
);

  localparam int IDX_W = $clog2(ENTRIES);

  mem_ctl_t         mem_ctl;
  logic [IDX_W-1:0] mem_addr;
  logic [PIX_W-1:0] mem_wdata;
  logic [PIX_W-1:0] mem_rdata;

  plt_ctrl #(
    .ENTRIES(ENTRIES)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_entry_index (in_entry_index),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_found_index(out_found_index),
    .out_found      (out_found),
    .out_red_out    (out_red_out),
    .out_green_out  (out_green_out),
    .out_blue_out   (out_blue_out),
    .mem_ctl        (mem_ctl),
    .mem_addr       (mem_addr),
    .mem_wdata      (mem_wdata),
    .mem_rdata      (mem_rdata)
  );

  plt_ram #(
    .ENTRIES(ENTRIES)
  ) u_ram (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (mem_ctl),
    .addr (mem_addr),
    .wdata(mem_wdata),
    .rdata(mem_rdata)
  );

endmodule

@@ sv/plt_ram.sv @@
// Palette memory with per-entry valid bits and a registered read port.
module plt_ram
  import plt_pkg::*;
#(
  parameter int ENTRIES = PLT_ENTRIES
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  mem_ctl_t                   ctl,
  input  logic [$clog2(ENTRIES)-1:0] addr,
  input  logic [PIX_W-1:0]           wdata,
  output logic [PIX_W-1:0]           rdata
);

  logic [PIX_W-1:0]   mem [ENTRIES];
  logic [ENTRIES-1:0] vld_r;
  logic [PIX_W-1:0]   mem_q_r;
  logic               vld_q_r;

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[addr] <= wdata;
    end
    if (ctl.re) begin
      mem_q_r <= mem[addr];
    end
  end

  // valid bits stand in for clearing the array at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      vld_q_r <= 1'b0;
    end else begin
      if (ctl.we) begin
        vld_r[addr] <= 1'b1;
      end
      if (ctl.re) begin
        vld_q_r <= vld_r[addr];
      end
    end
  end

  assign rdata = vld_q_r ? mem_q_r : '0;

endmodule

@@ sv/plt_ctrl.sv @@
// Sequencer, shared colour comparator and result registers.
module plt_ctrl
  import plt_pkg::*;
#(
  parameter int ENTRIES = PLT_ENTRIES
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 in_operation,
  input  logic [IDX_FIELD_W-1:0]     in_entry_index,
  input  logic [CH_RAW_W-1:0]        in_red,
  input  logic [CH_RAW_W-1:0]        in_green,
  input  logic [CH_RAW_W-1:0]        in_blue,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [IDX_FIELD_W-1:0]     out_found_index,
  output logic                       out_found,
  output logic [CH_SAVE_W-1:0]       out_red_out,
  output logic [CH_SAVE_W-1:0]       out_green_out,
  output logic [CH_SAVE_W-1:0]       out_blue_out,
  output mem_ctl_t                   mem_ctl,
  output logic [$clog2(ENTRIES)-1:0] mem_addr,
  output logic [PIX_W-1:0]           mem_wdata,
  input  logic [PIX_W-1:0]           mem_rdata
);

`include "palette_store_with_reverse_lookup_assert.svh"

  localparam int IDX_W = $clog2(ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  state_t                 state_r, state_nxt;
  logic [IDX_W-1:0]       addr_r, addr_nxt;
  logic [IDX_W-1:0]       cmp_idx_r, cmp_idx_nxt;
  logic [PIX_W-1:0]       key_r, key_nxt;
  logic                   rng_r, rng_nxt;
  logic [IDX_FIELD_W-1:0] res_idx_r, res_idx_nxt;
  logic                   res_found_r, res_found_nxt;
  logic [CH_SAVE_W-1:0]   res_red_r, res_red_nxt;
  logic [CH_SAVE_W-1:0]   res_green_r, res_green_nxt;
  logic [CH_SAVE_W-1:0]   res_blue_r, res_blue_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [IDX_FIELD_W-1:0] out_idx_r, out_idx_nxt;
  logic                   out_found_r, out_found_nxt;
  logic [CH_SAVE_W-1:0]   out_red_r, out_red_nxt;
  logic [CH_SAVE_W-1:0]   out_green_r, out_green_nxt;
  logic [CH_SAVE_W-1:0]   out_blue_r, out_blue_nxt;

  op_t  op;
  logic in_range;
  logic match;
  logic scan_end;
  logic out_free;

  assign op       = op_t'(in_operation);
  assign in_range = {1'b0, in_entry_index} < (IDX_FIELD_W + 1)'(ENTRIES);
  assign match    = (mem_rdata == key_r);
  assign scan_end = (cmp_idx_r == LAST_IDX);
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (op)
            OP_READ:    state_nxt = ST_READ;
            OP_RESOLVE: state_nxt = ST_SCAN;
            default:    state_nxt = ST_FINISH;
          endcase
        end
      end
      ST_READ:   state_nxt = ST_FINISH;
      ST_SCAN: begin
        if (match || scan_end) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    mem_ctl       = '0;
    mem_addr      = addr_r;
    mem_wdata     = {widen6(in_red), widen6(in_green), widen6(in_blue)};
    addr_nxt      = addr_r;
    cmp_idx_nxt   = cmp_idx_r;
    key_nxt       = key_r;
    rng_nxt       = rng_r;
    res_idx_nxt   = res_idx_r;
    res_found_nxt = res_found_r;
    res_red_nxt   = res_red_r;
    res_green_nxt = res_green_r;
    res_blue_nxt  = res_blue_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_idx_nxt   = out_idx_r;
    out_found_nxt = out_found_r;
    out_red_nxt   = out_red_r;
    out_green_nxt = out_green_r;
    out_blue_nxt  = out_blue_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          res_idx_nxt   = in_entry_index;
          res_found_nxt = 1'b0;
          res_red_nxt   = '0;
          res_green_nxt = '0;
          res_blue_nxt  = '0;
          rng_nxt       = in_range;
          key_nxt       = {in_red, in_green, in_blue};
          mem_addr      = in_entry_index[IDX_W-1:0];
          case (op)
            OP_WRITE: mem_ctl.we = in_range;
            OP_READ:  mem_ctl.re = 1'b1;
            OP_RESOLVE: begin
              // prime the scan with entry zero
              mem_ctl.re  = 1'b1;
              mem_addr    = '0;
              addr_nxt    = IDX_W'(1);
              cmp_idx_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        if (rng_r) begin
          res_red_nxt   = mem_rdata[PIX_W-1 -: CH_SAVE_W];
          res_green_nxt = mem_rdata[2*CH_RAW_W-1 -: CH_SAVE_W];
          res_blue_nxt  = mem_rdata[CH_RAW_W-1 -: CH_SAVE_W];
        end
      end
      ST_SCAN: begin
        // compare the entry fetched last cycle, fetch the next one
        mem_ctl.re    = !scan_end;
        mem_addr      = addr_r;
        addr_nxt      = addr_r + IDX_W'(1);
        cmp_idx_nxt   = addr_r;
        res_found_nxt = match;
        res_idx_nxt   = match ? IDX_FIELD_W'(cmp_idx_r) : '0;
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = res_idx_r;
          out_found_nxt = res_found_r;
          out_red_nxt   = res_red_r;
          out_green_nxt = res_green_r;
          out_blue_nxt  = res_blue_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r      <= addr_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    key_r       <= key_nxt;
    rng_r       <= rng_nxt;
    res_idx_r   <= res_idx_nxt;
    res_found_r <= res_found_nxt;
    res_red_r   <= res_red_nxt;
    res_green_r <= res_green_nxt;
    res_blue_r  <= res_blue_nxt;
    out_idx_r   <= out_idx_nxt;
    out_found_r <= out_found_nxt;
    out_red_r   <= out_red_nxt;
    out_green_r <= out_green_nxt;
    out_blue_r  <= out_blue_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_found_index = out_idx_r;
  assign out_found       = out_found_r;
  assign out_red_out     = out_red_r;
  assign out_green_out   = out_green_r;
  assign out_blue_out    = out_blue_r;

  `PLT_ASSERT_NEXT(a_scan_continues, clk, rst_n, (state_r == ST_SCAN) && !match && !scan_end, (state_r == ST_SCAN))
  `PLT_ASSERT_NEXT(a_match_ends_scan, clk, rst_n, (state_r == ST_SCAN) && match, (state_r == ST_FINISH) && res_found_r)
  `PLT_ASSERT_IMPLY(a_result_from_finish, clk, rst_n, $rose(out_valid_r), $past(state_r) == ST_FINISH)
  `PLT_ASSERT_IMPLY(a_found_no_colour, clk, rst_n, out_valid_r && out_found_r, (out_red_r == '0) && (out_green_r == '0) && (out_blue_r == '0))

endmodule

@@ tb/palette_store_with_reverse_lookup_tb.sv @@
// Self-checking testbench for the palette store with reverse colour lookup.
`timescale 1ns / 100ps

module palette_store_with_reverse_lookup_tb;
  import plt_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_CMDS = 600;
  localparam int CALM_TAIL = 40;
  localparam int SETTLE_CYCLES = 300;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] idx;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    bit         drain;
  } palette_cmd_t;

  typedef struct packed {
    logic [7:0] found_index;
    logic       found;
    logic [5:0] red;
    logic [5:0] green;
    logic [5:0] blue;
  } palette_reply_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] in_operation = 2'd0;
  logic [7:0] in_entry_index = 8'd0;
  logic [7:0] in_red = 8'd0;
  logic [7:0] in_green = 8'd0;
  logic [7:0] in_blue = 8'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_found_index;
  logic       out_found;
  logic [5:0] out_red_out;
  logic [5:0] out_green_out;
  logic [5:0] out_blue_out;

  palette_cmd_t   pending_cmds[$];
  palette_reply_t awaited_replies[$];
  logic [23:0]    colour_shadow[PLT_ENTRIES];
  logic [23:0]    written_colours[$];
  int             errors = 0;
  bit             in_took = 1'b0;
  int             send_gap = 0;
  int             stall_left = 0;
  bit             calm = 1'b0;

  palette_store_with_reverse_lookup dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_entry_index (in_entry_index),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_found_index(out_found_index),
    .out_found      (out_found),
    .out_red_out    (out_red_out),
    .out_green_out  (out_green_out),
    .out_blue_out   (out_blue_out)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Replicate the top two bits of a 6-bit level into the low end.
  function automatic logic [7:0] expand_level(input logic [7:0] raw);
    return {raw[5:0], 2'b00} | {6'b000000, raw[5:4]};
  endfunction

  function automatic palette_reply_t palette_apply(input palette_cmd_t c);
    palette_reply_t rep;
    logic [23:0]    stored;
    bit             hit;
    rep = '0;
    rep.found_index = c.idx;
    hit = 1'b0;
    if (c.op == OP_WRITE) begin
      if (int'(c.idx) < PLT_ENTRIES)
        colour_shadow[c.idx] = {expand_level(c.red), expand_level(c.green),
                                expand_level(c.blue)};
    end else if (c.op == OP_READ) begin
      if (int'(c.idx) < PLT_ENTRIES) begin
        stored = colour_shadow[c.idx];
        rep.red = stored[23:18];
        rep.green = stored[15:10];
        rep.blue = stored[7:2];
      end
    end else if (c.op == OP_RESOLVE) begin
      rep.found_index = 8'd0;
      // Lowest matching entry wins.
      for (int i = 0; i < PLT_ENTRIES; i++) begin
        if (!hit && colour_shadow[i] == {c.red, c.green, c.blue}) begin
          hit = 1'b1;
          rep.found = 1'b1;
          rep.found_index = i[7:0];
        end
      end
    end
    return rep;
  endfunction

  task automatic queue_cmd(input logic [1:0] op, input logic [7:0] idx,
                           input logic [7:0] r, input logic [7:0] g,
                           input logic [7:0] b, input bit drain);
    palette_cmd_t c;
    c.op = op;
    c.idx = idx;
    c.red = r;
    c.green = g;
    c.blue = b;
    c.drain = drain;
    if (op == OP_WRITE) written_colours.push_back({expand_level(r), expand_level(g),
                                                   expand_level(b)});
    pending_cmds.push_back(c);
  endtask

  // Raw VGA byte: half from a few levels to make repeats likely, high bits random.
  function automatic logic [7:0] pick_raw();
    logic [5:0] lvl;
    if ($urandom_range(0, 1) == 0) return 8'($urandom);
    case ($urandom_range(0, 3))
      0: lvl = 6'h00;
      1: lvl = 6'h3f;
      2: lvl = 6'h15;
      default: lvl = 6'h2a;
    endcase
    return {2'($urandom), lvl};
  endfunction

  function automatic logic [7:0] pick_index();
    int hot;
    if ($urandom_range(0, 3) != 0) return 8'($urandom);
    hot = $urandom_range(0, 4);
    return (hot < 3) ? 8'(hot) : 8'(251 + hot);
  endfunction

  function automatic logic [23:0] pick_target();
    case ($urandom_range(0, 5))
      0, 1, 2: begin
        if (written_colours.size() > 0)
          return written_colours[$urandom_range(0, written_colours.size() - 1)];
        return 24'h000000;
      end
      3: return {expand_level(pick_raw()), expand_level(pick_raw()),
                 expand_level(pick_raw())};
      4: return 24'h000000;
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // Input side: hold valid until the beat is taken, then maybe idle a while.
  always @(negedge clk) begin
    calm = (pending_cmds.size() <= CALM_TAIL);
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (in_took && !calm && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 18);
      in_took = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_cmds.size() > 0 &&
                   !(pending_cmds[0].drain && awaited_replies.size() > 0)) begin
        in_valid <= 1'b1;
        in_operation <= pending_cmds[0].op;
        in_entry_index <= pending_cmds[0].idx;
        in_red <= pending_cmds[0].red;
        in_green <= pending_cmds[0].green;
        in_blue <= pending_cmds[0].blue;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure in bursts.
  always @(negedge clk) begin
    if (!rst_n || calm) begin
      stall_left = 0;
      out_ready <= rst_n;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 17);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    palette_reply_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        if (pending_cmds.size() > 0) begin
          awaited_replies.push_back(palette_apply(pending_cmds[0]));
          pending_cmds.pop_front();
        end
        in_took = 1'b1;
      end
      if (out_valid && out_ready) begin
        if (awaited_replies.size() == 0) begin
          $display("%0t: unexpected result, expected none actual index %0d found %0d",
                   $time, out_found_index, out_found);
          errors++;
        end else begin
          want = awaited_replies.pop_front();
          check_field("found_index", want.found_index, out_found_index);
          check_field("found", {7'd0, want.found}, {7'd0, out_found});
          check_field("red_out", {2'd0, want.red}, {2'd0, out_red_out});
          check_field("green_out", {2'd0, want.green}, {2'd0, out_green_out});
          check_field("blue_out", {2'd0, want.blue}, {2'd0, out_blue_out});
        end
      end
    end
  end

  initial begin
    logic [23:0] tgt;
    int          sel;
    bit          drain;
    for (int i = 0; i < PLT_ENTRIES; i++) colour_shadow[i] = 24'h000000;

    // Directed: cleared palette, high raw bits, extremes, duplicates, misses, code 3.
    queue_cmd(OP_RESOLVE, 8'h5a, 8'h00, 8'h00, 8'h00, 1'b0);
    queue_cmd(OP_READ,    8'h00, 8'hff, 8'hff, 8'hff, 1'b0);
    queue_cmd(OP_READ,    8'hff, 8'h00, 8'h00, 8'h00, 1'b0);
    queue_cmd(OP_RESOLVE, 8'h00, 8'hff, 8'hff, 8'hff, 1'b0);
    queue_cmd(OP_WRITE,   8'hff, 8'hff, 8'hff, 8'hff, 1'b0);
    queue_cmd(OP_WRITE,   8'h00, 8'hc0, 8'h40, 8'h80, 1'b0);
    queue_cmd(OP_WRITE,   8'h05, 8'h3f, 8'h00, 8'h15, 1'b0);
    queue_cmd(OP_WRITE,   8'h07, 8'h7f, 8'hc0, 8'h95, 1'b0);
    queue_cmd(OP_READ,    8'hff, 8'h00, 8'h00, 8'h00, 1'b0);
    queue_cmd(OP_READ,    8'h05, 8'h00, 8'h00, 8'h00, 1'b0);
    queue_cmd(OP_READ,    8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    queue_cmd(OP_RESOLVE, 8'h00, 8'hff, 8'hff, 8'hff, 1'b0);
    queue_cmd(OP_RESOLVE, 8'hff, 8'hff, 8'h00, 8'h55, 1'b0);
    queue_cmd(OP_RESOLVE, 8'h11, 8'h01, 8'h00, 8'h00, 1'b0);
    queue_cmd(OP_RESOLVE, 8'h22, 8'h00, 8'h00, 8'h00, 1'b0);
    queue_cmd(OP_UNUSED,  8'haa, 8'hff, 8'hff, 8'hff, 1'b0);
    queue_cmd(OP_UNUSED,  8'h55, 8'h00, 8'h00, 8'h00, 1'b0);
    queue_cmd(OP_WRITE,   8'h00, 8'h2a, 8'h15, 8'h3f, 1'b0);
    queue_cmd(OP_READ,    8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    queue_cmd(OP_WRITE,   8'h05, 8'h00, 8'h00, 8'h00, 1'b0);
    queue_cmd(OP_RESOLVE, 8'h00, 8'hff, 8'h00, 8'h55, 1'b0);
    queue_cmd(OP_RESOLVE, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);

    for (int n = 0; n < RANDOM_CMDS; n++) begin
      sel = $urandom_range(0, 99);
      // Let everything in flight drain now and then.
      drain = (n % 150 == 0);
      if (sel < 40) begin
        queue_cmd(OP_WRITE, pick_index(), pick_raw(), pick_raw(), pick_raw(), drain);
      end else if (sel < 65) begin
        queue_cmd(OP_READ, pick_index(), 8'($urandom), 8'($urandom), 8'($urandom), drain);
      end else if (sel < 95) begin
        tgt = pick_target();
        queue_cmd(OP_RESOLVE, 8'($urandom), tgt[23:16], tgt[15:8], tgt[7:0], drain);
      end else begin
        queue_cmd(OP_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  drain);
      end
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_cmds.size() > 0 || awaited_replies.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

@@ palette_store_with_reverse_lookup.f @@
+incdir+sv
sv/plt_pkg.sv
sv/plt_ram.sv
sv/plt_ctrl.sv
sv/palette_store_with_reverse_lookup.sv
tb/palette_store_with_reverse_lookup_tb.sv
